/* rtl/pcf_pkg.sv */
// Shared widths, sideband types and the square-root step for the point-charge field pipeline.
package pcf_pkg;

	localparam int COORD_FRACTION_BITS = 24;

	localparam int COORD_W  = 32;
	localparam int D_W      = COORD_W + 1;
	localparam int CHARGE_W = 16;
	localparam int SCALE_W  = 32;
	localparam int BASE_W   = SCALE_W + CHARGE_W;
	localparam int SQ_W     = 2 * D_W;
	localparam int S2_W     = SQ_W;
	localparam int ROOT_W   = 49;
	localparam int RIN_W    = 2 * ROOT_W;
	localparam int REM_W    = ROOT_W + 3;
	localparam int SHIFT    = 2 * COORD_FRACTION_BITS - 16;
	localparam int PROD_W   = BASE_W + D_W;
	localparam int NUM_W    = PROD_W + SHIFT;
	localparam int DEN_W    = S2_W + ROOT_W;
	localparam int FIELD_W  = 48;
	localparam int HI_W     = NUM_W - FIELD_W;

	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(405314);
	localparam logic [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

	typedef struct packed {
		logic [2:0][PROD_W-1:0] prod;
		logic [S2_W-1:0]        s2;
		logic [2:0]             neg;
		logic                   coin;
	} sq_side_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       coin;
	} div_side_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_step_t;

	// one bit of a restoring integer square root
	function automatic root_step_t sqrt_step(input logic [REM_W-1:0] rem_in,
		input logic [ROOT_W-1:0] root_in, input logic [1:0] bits);
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		logic             ge;
		root_step_t       r;
		cur   = {rem_in[REM_W-3:0], bits};
		trial = REM_W'({root_in, 2'b01});
		ge    = cur >= trial;
		r.rem  = ge ? cur - trial : cur;
		r.root = {root_in[ROOT_W-2:0], ge};
		return r;
	endfunction

endpackage

/* rtl/point_charge_field_top.sv */
// Coulomb point-charge field: E = k*q*d/|d|^3 in fixed point, fully pipelined.
// Throughput: one transaction per cycle when not stalled; depth is set by the
// 49-stage square root and the 49-stage divider (one setup stage, then one
// quotient bit per stage).
// Reset: arst_n clears all valid bits, including the skid register's, and
// returns coulomb_scale to 405314; pipeline and skid data are not reset.
module point_charge_field_top (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wr_en,
	input  logic [31:0]         cfg_wr_data,
	// input channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  test_x,
	input  logic signed [31:0]  test_y,
	input  logic signed [31:0]  test_z,
	input  logic signed [31:0]  source_x,
	input  logic signed [31:0]  source_y,
	input  logic signed [31:0]  source_z,
	input  logic signed [15:0]  source_charge,
	// output channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [47:0]  field_x,
	output logic signed [47:0]  field_y,
	output logic signed [47:0]  field_z,
	output logic                coincident,
	output logic                saturated
);

	localparam int D_W    = pcf_pkg::D_W;
	localparam int FW     = pcf_pkg::FIELD_W;
	localparam int R_LO_W = 25;
	localparam int R_HI_W = pcf_pkg::ROOT_W - R_LO_W;
	localparam int S_LO_W = 33;
	localparam int S_HI_W = pcf_pkg::S2_W - S_LO_W;

	// Whole pipeline moves together; it freezes only while the skid register
	// holds a result, so the input stall is a plain register.
	logic en;
	logic skid_valid_q;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// coulomb_scale register
	logic [pcf_pkg::SCALE_W-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= pcf_pkg::SCALE_RESET;
		end else if (cfg_wr_en) begin
			scale_q <= cfg_wr_data;
		end
	end

	// ---------------- S1: differences, magnitudes, k*|q| ----------------
	logic [2:0][D_W-1:0]              mag_c;
	logic [2:0]                       dneg_c;
	logic [pcf_pkg::CHARGE_W-1:0]     qmag_c;

	always_comb begin
		logic signed [31:0] tp [3];
		logic signed [31:0] sp [3];
		logic [D_W-1:0]     d;
		tp[0] = test_x;   tp[1] = test_y;   tp[2] = test_z;
		sp[0] = source_x; sp[1] = source_y; sp[2] = source_z;
		for (int i = 0; i < 3; i++) begin
			d         = {tp[i][31], tp[i]} - {sp[i][31], sp[i]};
			dneg_c[i] = d[D_W-1];
			mag_c[i]  = d[D_W-1] ? D_W'(-d) : d;
		end
		qmag_c = source_charge[15] ? 16'(-source_charge) : source_charge;
	end

	logic                              v_s1;
	logic [2:0][D_W-1:0]               mag_s1;
	logic [2:0]                        dneg_s1;
	logic                              qneg_s1;
	logic [pcf_pkg::BASE_W-1:0]        base_s1;

	// ---------------- S2: squares and the charge*distance products ----------------
	logic                              v_s2;
	logic [2:0][pcf_pkg::SQ_W-1:0]     sq_s2;
	logic [2:0][D_W+31:0]              pl_s2;
	logic [2:0][D_W+15:0]              ph_s2;
	logic [2:0]                        neg_s2;
	logic                              coin_s2;

	// ---------------- S3: |d|^2 and full numerators ----------------
	logic                              v_s3;
	logic [pcf_pkg::S2_W-1:0]          s2_s3;
	logic [2:0][pcf_pkg::PROD_W-1:0]   prod_s3;
	logic [2:0]                        neg_s3;
	logic                              coin_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_c;
			dneg_s1 <= dneg_c;
			qneg_s1 <= source_charge[15];
			base_s1 <= pcf_pkg::BASE_W'(scale_q) * pcf_pkg::BASE_W'(qmag_c);

			for (int i = 0; i < 3; i++) begin
				sq_s2[i]  <= pcf_pkg::SQ_W'(mag_s1[i]) * pcf_pkg::SQ_W'(mag_s1[i]);
				pl_s2[i]  <= (D_W+32)'(base_s1[31:0]) * (D_W+32)'(mag_s1[i]);
				ph_s2[i]  <= (D_W+16)'(base_s1[47:32]) * (D_W+16)'(mag_s1[i]);
				neg_s2[i] <= qneg_s1 ^ dneg_s1[i];
			end
			coin_s2 <= (mag_s1[0] == '0) && (mag_s1[1] == '0) && (mag_s1[2] == '0);

			s2_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= pcf_pkg::PROD_W'(pl_s2[i])
					+ (pcf_pkg::PROD_W'(ph_s2[i]) << 32);
			end
			neg_s3  <= neg_s2;
			coin_s3 <= coin_s2;
		end
	end

	// ---------------- square root of |d|^2 * 2^32 ----------------
	pcf_pkg::sq_side_t           sq_side_in;
	pcf_pkg::sq_side_t           sq_side_out;
	logic                        sq_valid;
	logic [pcf_pkg::ROOT_W-1:0]  sq_root;

	always_comb begin
		sq_side_in.prod = prod_s3;
		sq_side_in.s2   = s2_s3;
		sq_side_in.neg  = neg_s3;
		sq_side_in.coin = coin_s3;
	end

	pcf_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.x         ({s2_s3, 32'b0}),
		.side_in   (sq_side_in),
		.out_valid (sq_valid),
		.root      (sq_root),
		.side_out  (sq_side_out)
	);

	// ---------------- S4/S5: denominator |d|^2 * R as four partial products ----------------
	logic                                 v_s4;
	logic [S_LO_W+R_LO_W-1:0]             pp00_s4;
	logic [S_LO_W+R_HI_W-1:0]             pp01_s4;
	logic [S_HI_W+R_LO_W-1:0]             pp10_s4;
	logic [S_HI_W+R_HI_W-1:0]             pp11_s4;
	logic [2:0][pcf_pkg::PROD_W-1:0]      prod_s4;
	pcf_pkg::div_side_t                   dside_s4;

	logic                                 v_s5;
	logic [pcf_pkg::DEN_W-1:0]            den_s5;
	logic [2:0][pcf_pkg::PROD_W-1:0]      prod_s5;
	pcf_pkg::div_side_t                   dside_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_valid;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s4 <= sq_side_out.s2[S_LO_W-1:0] * sq_root[R_LO_W-1:0];
			pp01_s4 <= sq_side_out.s2[S_LO_W-1:0] * sq_root[pcf_pkg::ROOT_W-1:R_LO_W];
			pp10_s4 <= sq_side_out.s2[pcf_pkg::S2_W-1:S_LO_W] * sq_root[R_LO_W-1:0];
			pp11_s4 <= sq_side_out.s2[pcf_pkg::S2_W-1:S_LO_W]
				* sq_root[pcf_pkg::ROOT_W-1:R_LO_W];
			prod_s4       <= sq_side_out.prod;
			dside_s4.neg  <= sq_side_out.neg;
			dside_s4.coin <= sq_side_out.coin;

			den_s5 <= pcf_pkg::DEN_W'(pp00_s4)
				+ (pcf_pkg::DEN_W'(pp01_s4) << R_LO_W)
				+ (pcf_pkg::DEN_W'(pp10_s4) << S_LO_W)
				+ (pcf_pkg::DEN_W'(pp11_s4) << (S_LO_W + R_LO_W));
			prod_s5  <= prod_s4;
			dside_s5 <= dside_s4;
		end
	end

	// ---------------- division, one quotient bit per stage ----------------
	logic                        dv_valid;
	logic [2:0][FW-1:0]          dv_quot;
	logic [2:0]                  dv_ovf;
	pcf_pkg::div_side_t          dv_side;

	pcf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.den       (den_s5),
		.prod      (prod_s5),
		.side_in   (dside_s5),
		.out_valid (dv_valid),
		.quot      (dv_quot),
		.ovf       (dv_ovf),
		.side_out  (dv_side)
	);

	// ---------------- S6: sign, saturation, coincident override ----------------
	logic [2:0][FW-1:0] fld_c;
	logic               sat_c;

	always_comb begin
		sat_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (!dv_side.neg[i]) begin
				if (dv_ovf[i] || dv_quot[i][FW-1]) begin
					fld_c[i] = pcf_pkg::FIELD_MAX;
					sat_c    = 1'b1;
				end else begin
					fld_c[i] = dv_quot[i];
				end
			end else begin
				if (dv_ovf[i] || (dv_quot[i] > pcf_pkg::FIELD_MIN)) begin
					fld_c[i] = pcf_pkg::FIELD_MIN;
					sat_c    = 1'b1;
				end else begin
					fld_c[i] = FW'(-dv_quot[i]);
				end
			end
		end
		if (dv_side.coin) begin
			fld_c = '0;
			sat_c = 1'b0;
		end
	end

	logic                v_s6;
	logic [2:0][FW-1:0]  fld_s6;
	logic                coin_s6;
	logic                sat_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fld_s6  <= fld_c;
			coin_s6 <= dv_side.coin;
			sat_s6  <= sat_c;
		end
	end

	// ---------------- output skid register ----------------
	// Catches the last stage when the consumer stalls, since the pipeline
	// advanced in that same cycle.
	logic [2:0][FW-1:0]  fld_q;
	logic                coin_q;
	logic                sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_stall) begin
				skid_valid_q <= 1'b0;
			end
		end else if (v_s6 && out_stall) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q) begin
			fld_q  <= fld_s6;
			coin_q <= coin_s6;
			sat_q  <= sat_s6;
		end
	end

	assign out_valid  = skid_valid_q || v_s6;
	assign field_x    = skid_valid_q ? fld_q[0] : fld_s6[0];
	assign field_y    = skid_valid_q ? fld_q[1] : fld_s6[1];
	assign field_z    = skid_valid_q ? fld_q[2] : fld_s6[2];
	assign coincident = skid_valid_q ? coin_q : coin_s6;
	assign saturated  = skid_valid_q ? sat_q : sat_s6;

	// ---------------- assertions ----------------
	a_coin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coincident |-> field_x == '0 && field_y == '0 && field_z == '0
			&& !saturated)
		else $error("coincident transaction with nonzero field");

	a_sat_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(field_x == pcf_pkg::FIELD_MAX) || (field_x == pcf_pkg::FIELD_MIN)
			|| (field_y == pcf_pkg::FIELD_MAX) || (field_y == pcf_pkg::FIELD_MIN)
			|| (field_z == pcf_pkg::FIELD_MAX) || (field_z == pcf_pkg::FIELD_MIN))
		else $error("saturated flag without a clipped component");

	a_skid_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_stall) && $past(v_s6))
		else $error("skid loaded without a stalled result");

	// bubble data is never reset, so only a valid last stage is checked
	a_skid_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |=> $stable(v_s6) && (!v_s6 || $stable(fld_s6)))
		else $error("pipeline moved while skid register was full");

endmodule

/* rtl/pcf_sqrt.sv */
// Pipelined bit-by-bit square root, one result bit per stage, with sideband.
module pcf_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [pcf_pkg::RIN_W-1:0]     x,
	input  pcf_pkg::sq_side_t             side_in,
	output logic                          out_valid,
	output logic [pcf_pkg::ROOT_W-1:0]    root,
	output pcf_pkg::sq_side_t             side_out
);

	localparam int N = pcf_pkg::ROOT_W;

	logic                         v_sk    [N];
	logic [pcf_pkg::REM_W-1:0]    rem_sk  [N];
	logic [pcf_pkg::ROOT_W-1:0]   root_sk [N];
	logic [pcf_pkg::RIN_W-1:0]    x_sk    [N];
	pcf_pkg::sq_side_t            side_sk [N];

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic                       v_prev;
		logic [pcf_pkg::REM_W-1:0]  rem_prev;
		logic [pcf_pkg::ROOT_W-1:0] root_prev;
		logic [pcf_pkg::RIN_W-1:0]  x_prev;
		pcf_pkg::sq_side_t          side_prev;
		pcf_pkg::root_step_t        nxt;

		if (j == 0) begin : g_first
			assign v_prev    = in_valid;
			assign rem_prev  = '0;
			assign root_prev = '0;
			assign x_prev    = x;
			assign side_prev = side_in;
		end else begin : g_next
			assign v_prev    = v_sk[j-1];
			assign rem_prev  = rem_sk[j-1];
			assign root_prev = root_sk[j-1];
			assign x_prev    = x_sk[j-1];
			assign side_prev = side_sk[j-1];
		end

		assign nxt = pcf_pkg::sqrt_step(rem_prev, root_prev,
			x_prev[pcf_pkg::RIN_W-1 -: 2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[j] <= 1'b0;
			end else if (en) begin
				v_sk[j] <= v_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[j]  <= nxt.rem;
				root_sk[j] <= nxt.root;
				x_sk[j]    <= x_prev << 2;
				side_sk[j] <= side_prev;
			end
		end
	end

	assign out_valid = v_sk[N-1];
	assign root      = root_sk[N-1];
	assign side_out  = side_sk[N-1];

endmodule

/* rtl/pcf_div.sv */
// Three-lane pipelined restoring divider: 48 quotient bits plus overflow detect.
module pcf_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic [pcf_pkg::DEN_W-1:0]             den,
	input  logic [2:0][pcf_pkg::PROD_W-1:0]       prod,
	input  pcf_pkg::div_side_t                    side_in,
	output logic                                  out_valid,
	output logic [2:0][pcf_pkg::FIELD_W-1:0]      quot,
	output logic [2:0]                            ovf,
	output pcf_pkg::div_side_t                    side_out
);

	localparam int N = pcf_pkg::FIELD_W + 1;

	logic                                    v_sk    [N];
	logic [pcf_pkg::DEN_W-1:0]               den_sk  [N];
	logic [2:0][pcf_pkg::DEN_W-1:0]          rem_sk  [N];
	logic [2:0][pcf_pkg::FIELD_W-1:0]        lo_sk   [N];
	logic [2:0][pcf_pkg::FIELD_W-1:0]        q_sk    [N];
	logic [2:0]                              ovf_sk  [N];
	pcf_pkg::div_side_t                      side_sk [N];

	// first stage: split the numerator, flag quotients of 2^48 or more
	logic [2:0][pcf_pkg::DEN_W-1:0]   rem0;
	logic [2:0][pcf_pkg::FIELD_W-1:0] lo0;
	logic [2:0]                       ovf0;

	always_comb begin
		logic [pcf_pkg::NUM_W-1:0] num;
		logic [pcf_pkg::HI_W-1:0]  hi;
		for (int i = 0; i < 3; i++) begin
			num     = pcf_pkg::NUM_W'(prod[i]) << pcf_pkg::SHIFT;
			hi      = num[pcf_pkg::NUM_W-1:pcf_pkg::FIELD_W];
			ovf0[i] = pcf_pkg::DEN_W'(hi) >= den;
			rem0[i] = ovf0[i] ? '0 : pcf_pkg::DEN_W'(hi);
			lo0[i]  = num[pcf_pkg::FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sk[0] <= 1'b0;
		end else if (en) begin
			v_sk[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_sk[0]  <= den;
			rem_sk[0]  <= rem0;
			lo_sk[0]   <= lo0;
			q_sk[0]    <= '0;
			ovf_sk[0]  <= ovf0;
			side_sk[0] <= side_in;
		end
	end

	for (genvar j = 1; j < N; j++) begin : g_stage
		logic [2:0][pcf_pkg::DEN_W-1:0]   rem_n;
		logic [2:0][pcf_pkg::FIELD_W-1:0] q_n;

		always_comb begin
			logic [pcf_pkg::DEN_W:0] trial;
			logic                    ge;
			for (int i = 0; i < 3; i++) begin
				trial    = {rem_sk[j-1][i], lo_sk[j-1][i][pcf_pkg::FIELD_W-1]};
				ge       = trial >= {1'b0, den_sk[j-1]};
				rem_n[i] = ge ? pcf_pkg::DEN_W'(trial - {1'b0, den_sk[j-1]})
					: trial[pcf_pkg::DEN_W-1:0];
				q_n[i]   = {q_sk[j-1][i][pcf_pkg::FIELD_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[j] <= 1'b0;
			end else if (en) begin
				v_sk[j] <= v_sk[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_sk[j]  <= den_sk[j-1];
				rem_sk[j]  <= rem_n;
				for (int i = 0; i < 3; i++) begin
					lo_sk[j][i] <= lo_sk[j-1][i] << 1;
				end
				q_sk[j]    <= q_n;
				ovf_sk[j]  <= ovf_sk[j-1];
				side_sk[j] <= side_sk[j-1];
			end
		end
	end

	assign out_valid = v_sk[N-1];
	assign quot      = q_sk[N-1];
	assign ovf       = ovf_sk[N-1];
	assign side_out  = side_sk[N-1];

endmodule
